### rtl/spss_pkg.sv
// ----------------------------------------------------------------------------
// spss_pkg
// Shared types and constants of the sorted pair-sum search block.
// ----------------------------------------------------------------------------
package spss_pkg;

	// defaults of the top level parameters
	localparam int LIST_DEPTH_DEFAULT    = 128;
	localparam int ELEMENT_WIDTH_DEFAULT = 16;

	// fixed field widths
	localparam int KIND_W   = 2;
	localparam int INDEX_W  = 7;
	localparam int VALUE_W  = 16;
	localparam int TARGET_W = 17;
	localparam int SPAN_W   = 8;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD_FIRST  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY       = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_LENGTH_IN_USE = 1'b0;

	localparam logic [SPAN_W-1:0] LENGTH_RESET = 8'd128;

	typedef enum logic {
		ST_IDLE,
		ST_STEP
	} spss_state_t;

	typedef struct packed {
		logic                   found;
		logic [VALUE_W-1:0]     first_value;
		logic [VALUE_W-1:0]     second_value;
		logic [INDEX_W-1:0]     first_position;
		logic [INDEX_W-1:0]     second_position;
	} spss_result_t;

endpackage

### rtl/spss_list_mem.sv
// ----------------------------------------------------------------------------
// spss_list_mem
// One list store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module spss_list_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/spss_search.sv
// ----------------------------------------------------------------------------
// spss_search
// Two-pointer walk over both list stores, one pointer step per cycle.
// ----------------------------------------------------------------------------
module spss_search #(
	parameter int LIST_DEPTH = 128,
	parameter int ELEMENT_WIDTH = 16,
	parameter int ADDR_W = $clog2(LIST_DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       query,
	input  logic [spss_pkg::TARGET_W-1:0] target,
	input  logic [spss_pkg::SPAN_W-1:0]   length_in_use,
	output logic                       busy,
	output logic [ADDR_W-1:0]          first_raddr,
	output logic [ADDR_W-1:0]          second_raddr,
	input  logic [ELEMENT_WIDTH-1:0]   first_rdata,
	input  logic [ELEMENT_WIDTH-1:0]   second_rdata,
	output logic                       done,
	output spss_pkg::spss_result_t     result
);
	import spss_pkg::*;

	localparam int SUM_W = (ELEMENT_WIDTH + 1 > TARGET_W) ? ELEMENT_WIDTH + 1 : TARGET_W;

	spss_state_t         state_q, state_d;
	logic [SPAN_W-1:0]   a_q, a_d, b_q, b_d, n_q, span;
	logic [TARGET_W-1:0] target_q;
	logic                done_q, done_d;
	spss_result_t        result_q, result_d;

	logic [SUM_W-1:0]    sum;
	logic                hit, below, exhausted;
	logic [SPAN_W-1:0]   a_inc, b_dec;

	// lengths above the store depth act as the depth
	assign span = (32'(length_in_use) > LIST_DEPTH) ? SPAN_W'(LIST_DEPTH) : length_in_use;

	assign sum   = SUM_W'(first_rdata) + SUM_W'(second_rdata);
	assign hit   = (sum == SUM_W'(target_q));
	assign below = (sum < SUM_W'(target_q));
	assign a_inc = a_q + 8'd1;
	assign b_dec = b_q - 8'd1;
	// b counts one above the second pointer
	assign exhausted = below ? (a_inc == n_q) : (b_dec == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (query && span != '0) state_d = ST_STEP;
			end
			ST_STEP: begin
				if (hit || exhausted) state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		a_d          = a_q;
		b_d          = b_q;
		done_d       = 1'b0;
		result_d     = '0;
		first_raddr  = '0;
		second_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				a_d          = '0;
				b_d          = span;
				first_raddr  = '0;
				second_raddr = ADDR_W'(span - 8'd1);
				done_d       = query && (span == '0);
			end
			ST_STEP: begin
				if (!hit) begin
					if (below) begin
						a_d = a_inc;
					end else begin
						b_d = b_dec;
					end
				end
				first_raddr  = ADDR_W'(a_d);
				second_raddr = ADDR_W'(b_d - 8'd1);
				done_d       = hit || exhausted;
				if (hit) begin
					result_d.found           = 1'b1;
					result_d.first_value     = VALUE_W'(first_rdata);
					result_d.second_value    = VALUE_W'(second_rdata);
					result_d.first_position  = INDEX_W'(a_q);
					result_d.second_position = INDEX_W'(b_dec);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_q     <= '0;
			b_q     <= '0;
			n_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			a_q     <= a_d;
			b_q     <= b_d;
			done_q  <= done_d;
			if (state_q == ST_IDLE && query) begin
				n_q <= span;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && query) begin
			target_q <= target;
		end
		result_q <= result_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

### rtl/sorted_pair_sum_search.sv
// ----------------------------------------------------------------------------
// sorted_pair_sum_search
// Two stored ascending lists and a two-pointer search for a pair with a given sum.
// ----------------------------------------------------------------------------
// channel   direction  signals
// command   in         start, busy, kind, index, value, target
// result    out        done, found, first_value, second_value,
//                      first_position, second_position
// config    in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// a load word leaves busy low and no result follows
// a query holds busy while the pointers step, at most 2*n-1 steps with n
// the length in use, the result strobe following in the cycle after the last step
// one step per cycle is set by the read-compare-readdress loop through both list rams
// a query with length zero answers not found in the cycle after it is taken
// async reset clears the control; list contents are undefined until loaded
// results are shown for one cycle on done and cannot be held off
// ----------------------------------------------------------------------------
module sorted_pair_sum_search #(
	parameter int LIST_DEPTH = spss_pkg::LIST_DEPTH_DEFAULT,
	parameter int ELEMENT_WIDTH = spss_pkg::ELEMENT_WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [spss_pkg::KIND_W-1:0]   kind,
	input  logic [spss_pkg::INDEX_W-1:0]  index,
	input  logic [spss_pkg::VALUE_W-1:0]  value,
	input  logic [spss_pkg::TARGET_W-1:0] target,
	output logic                          done,
	output logic                          found,
	output logic [spss_pkg::VALUE_W-1:0]  first_value,
	output logic [spss_pkg::VALUE_W-1:0]  second_value,
	output logic [spss_pkg::INDEX_W-1:0]  first_position,
	output logic [spss_pkg::INDEX_W-1:0]  second_position,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [spss_pkg::PADDR_W-1:0]  paddr,
	input  logic [spss_pkg::PDATA_W-1:0]  pwdata,
	output logic [spss_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import spss_pkg::*;

	localparam int ADDR_W = $clog2(LIST_DEPTH);

	logic [SPAN_W-1:0]        length_q;
	logic                     accept, in_range, query;
	logic                     first_we, second_we;
	logic [ADDR_W-1:0]        waddr;
	logic [ELEMENT_WIDTH-1:0] wdata;
	logic [ADDR_W-1:0]        first_raddr, second_raddr;
	logic [ELEMENT_WIDTH-1:0] first_rdata, second_rdata;
	spss_result_t             result;

	// config register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LENGTH_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_LENGTH_IN_USE) begin
			length_q <= pwdata[SPAN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_LENGTH_IN_USE) ? PDATA_W'(length_q) : '0;

	// load words go straight to the list rams
	assign accept    = start && !busy;
	assign in_range  = (32'(index) < LIST_DEPTH);
	assign first_we  = accept && in_range && (kind == KIND_LOAD_FIRST);
	assign second_we = accept && in_range && (kind == KIND_LOAD_SECOND);
	assign query     = accept && (kind == KIND_QUERY);
	assign waddr     = ADDR_W'(index);
	assign wdata     = ELEMENT_WIDTH'(value);

	spss_list_mem #(
		.DEPTH (LIST_DEPTH),
		.WIDTH (ELEMENT_WIDTH)
	) u_first_mem (
		.clk   (clk),
		.we    (first_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (first_raddr),
		.rdata (first_rdata)
	);

	spss_list_mem #(
		.DEPTH (LIST_DEPTH),
		.WIDTH (ELEMENT_WIDTH)
	) u_second_mem (
		.clk   (clk),
		.we    (second_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (second_raddr),
		.rdata (second_rdata)
	);

	spss_search #(
		.LIST_DEPTH    (LIST_DEPTH),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_search (
		.clk           (clk),
		.arst_n        (arst_n),
		.query         (query),
		.target        (target),
		.length_in_use (length_q),
		.busy          (busy),
		.first_raddr   (first_raddr),
		.second_raddr  (second_raddr),
		.first_rdata   (first_rdata),
		.second_rdata  (second_rdata),
		.done          (done),
		.result        (result)
	);

	assign found           = result.found;
	assign first_value     = result.first_value;
	assign second_value    = result.second_value;
	assign first_position  = result.first_position;
	assign second_position = result.second_position;

endmodule
